FILE: design/conv3x3_pkg.sv
// Shared types and constants of the 3x3 image filter.
// Holds the payload structs, register indexes and reset values.
// No dependencies.
package conv3x3_pkg;

    // Default line and frame limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Kernel geometry
    localparam int KSIZE = 3;
    localparam int KTAPS = 9;
    localparam int COEF_W = 16;

    // Configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    // Reset values: identity kernel, full-size frame
    localparam logic [CFG_DATA_W-1:0]   RST_COEF_EDGE    = 48'h0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0]   RST_COEF_MID     = 48'h0000_0100_0000;
    localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 12'd2048;
    localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd4096;

    // Input item
    typedef struct packed {
        logic [7:0] pixel_in;
        logic       flush;
    } pix_in_t;

    // Result item
    typedef struct packed {
        logic [7:0] pixel_out;
        logic       last_of_frame;
    } pix_out_t;

endpackage

FILE: design/conv3x3_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the line stores of the 3x3 image filter.
// No dependencies.
module conv3x3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/conv3x3_image_filter_core.sv
// Top level of the 3x3 image filter: position tracking, line stores, window,
// kernel pipeline and result queue.
// Depends on conv3x3_pkg and conv3x3_ram.
//
//   channel  signals                          transfer when
//   in       in_valid in_ready in_data        in_valid && in_ready
//   out      out_valid out_ready out_data     out_valid && out_ready
//   cfg      cfg_we cfg_index cfg_data        cfg_we
//
// One pixel per clock sustained while the queue has room; a result passes from
// the item that completes its neighborhood through the line store read and the
// multiply, partial-sum and final-sum stages into the queue.
// in_ready depends only on queue fill plus items in flight, never on out_ready.
// Reset clears position, window and queue; line stores need no clearing pass.
// in_ready drops once queued results plus items in flight reach eight.
module conv3x3_image_filter_core
    import conv3x3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pix_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pix_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
    localparam int TERM_W = 17;
    localparam int PART_W = TERM_W + 2;
    localparam int SUM_W  = TERM_W + 4;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Pixel times Q8.8 coefficient, truncated toward zero
    function automatic logic signed [TERM_W-1:0] weigh(
        input logic [7:0]               pix,
        input logic signed [COEF_W-1:0] coef
    );
        logic signed [24:0] prod;
        logic signed [24:0] biased;
        prod   = $signed({1'b0, pix}) * coef;
        biased = prod + (prod[24] ? 25'sd255 : 25'sd0);
        return biased[24:8];
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_DATA_W-1:0]   coef_top_reg;
    logic [CFG_DATA_W-1:0]   coef_mid_reg;
    logic [CFG_DATA_W-1:0]   coef_bottom_reg;
    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg     <= RST_COEF_EDGE;
            coef_mid_reg     <= RST_COEF_MID;
            coef_bottom_reg  <= RST_COEF_EDGE;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_TOP:     coef_top_reg     <= cfg_data;
                REG_COEF_MID:     coef_mid_reg     <= cfg_data;
                REG_COEF_BOTTOM:  coef_bottom_reg  <= cfg_data;
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp sizes to 1..MAX
    logic [WCNT_W-1:0] w_eff;
    logic [HCNT_W-1:0] h_eff;

    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = WCNT_W'(1);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            w_eff = WCNT_W'(MAX_WIDTH);
        else
            w_eff = WCNT_W'(image_width_reg);

        if (image_height_reg == '0)
            h_eff = HCNT_W'(1);
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HCNT_W'(MAX_HEIGHT);
        else
            h_eff = HCNT_W'(image_height_reg);
    end

    // ---------------------------------------------------------------
    // Accept stage: position, result coordinates and edge masks
    // ---------------------------------------------------------------
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              in_accept;
    logic [7:0]        pix_eff;
    logic              col_pos, row_ok, emit, last;
    logic [ROW_W-1:0]  ro;
    logic [WCNT_W-1:0] co;
    logic [KSIZE-1:0]  row_valid, col_valid;
    logic [KTAPS-1:0]  mask;
    logic [WCNT_W-1:0] col_inc, col_step;
    logic [ROW_W-1:0]  row_step;

    assign in_accept = in_valid && in_ready;
    assign pix_eff   = in_data.flush ? 8'd0 : in_data.pixel_in;

    always_comb
    begin
        col_pos = (col_reg != '0);
        row_ok  = col_pos ? (row_reg >= ROW_W'(1)) : (row_reg >= ROW_W'(2));
        ro      = col_pos ? (row_reg - ROW_W'(1)) : (row_reg - ROW_W'(2));
        co      = col_pos ? (WCNT_W'(col_reg) - WCNT_W'(1)) : (w_eff - WCNT_W'(1));
        emit    = row_ok && (32'(ro) < 32'(h_eff)) && (32'(co) < 32'(w_eff));
        last    = emit && (32'(ro) + 32'd1 == 32'(h_eff)) && (32'(co) + 32'd1 == 32'(w_eff));

        row_valid = {(32'(ro) + 32'd1 < 32'(h_eff)), 1'b1, (ro != '0)};
        col_valid = {(32'(co) + 32'd1 < 32'(w_eff)), 1'b1, (co != '0)};
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                mask[i*KSIZE + j] = row_valid[i] && col_valid[j];
            end
        end

        // Advance position; wrap at end of row and at end of frame
        col_inc = WCNT_W'(col_reg) + WCNT_W'(1);
        if (col_inc >= w_eff)
        begin
            col_step = '0;
            row_step = row_reg + ROW_W'(1);
        end
        else
        begin
            col_step = col_inc;
            row_step = row_reg;
        end
        if (last || (32'(row_step) > 32'(h_eff) + 32'd1))
        begin
            col_step = '0;
            row_step = '0;
        end

        col_next = in_accept ? COL_W'(col_step) : col_reg;
        row_next = in_accept ? row_step : row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: line store read data, write back, window shift
    // ---------------------------------------------------------------
    logic             s1_valid_reg;
    logic [7:0]       s1_pix_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic             s1_fwd_reg;
    logic [7:0]       s1_fwd_top_reg;
    logic [7:0]       s1_fwd_mid_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic [KTAPS-1:0] s1_mask_reg;
    logic [7:0]       upper_rdata, middle_rdata;
    logic [7:0]       s1_top, s1_mid;

    // Bypass the store when the previous item writes the same column
    assign s1_top = s1_fwd_reg ? s1_fwd_top_reg : upper_rdata;
    assign s1_mid = s1_fwd_reg ? s1_fwd_mid_reg : middle_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg     <= pix_eff;
            s1_addr_reg    <= col_reg;
            s1_fwd_reg     <= s1_valid_reg && (s1_addr_reg == col_reg);
            s1_fwd_top_reg <= s1_mid;
            s1_fwd_mid_reg <= s1_pix_reg;
            s1_emit_reg    <= emit;
            s1_last_reg    <= last;
            s1_mask_reg    <= mask;
        end
    end

    conv3x3_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (s1_mid),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (upper_rdata)
    );

    conv3x3_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (s1_pix_reg),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (middle_rdata)
    );

    logic [7:0] window_reg  [KTAPS];
    logic [7:0] window_next [KTAPS];

    // Shift the window left by one column and insert the new column
    always_comb
    begin
        for (int k = 0; k < KTAPS; k++)
        begin
            window_next[k] = window_reg[k];
        end
        if (s1_valid_reg)
        begin
            for (int i = 0; i < KSIZE; i++)
            begin
                for (int j = 0; j < KSIZE - 1; j++)
                begin
                    window_next[i*KSIZE + j] = window_reg[i*KSIZE + j + 1];
                end
            end
            window_next[KSIZE - 1]         = s1_top;
            window_next[2*KSIZE - 1]       = s1_mid;
            window_next[KSIZE*KSIZE - 1]   = s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KTAPS; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < KTAPS; k++)
            begin
                window_reg[k] <= window_next[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: nine weighted taps
    // ---------------------------------------------------------------
    logic             s2_valid_reg;
    logic             s2_last_reg;
    logic [KTAPS-1:0] s2_mask_reg;
    logic [CFG_DATA_W-1:0] coef_rows [KSIZE];
    logic signed [TERM_W-1:0] terms [KTAPS];

    assign coef_rows[0] = coef_top_reg;
    assign coef_rows[1] = coef_mid_reg;
    assign coef_rows[2] = coef_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg <= s1_last_reg;
        s2_mask_reg <= s1_mask_reg;
    end

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                if (s2_mask_reg[i*KSIZE + j])
                    terms[i*KSIZE + j] = weigh(window_reg[i*KSIZE + j],
                        $signed(coef_rows[i][COEF_W*j +: COEF_W]));
                else
                    terms[i*KSIZE + j] = '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: row partial sums
    // ---------------------------------------------------------------
    logic                     s3_valid_reg;
    logic                     s3_last_reg;
    logic signed [TERM_W-1:0] s3_term_reg [KTAPS];
    logic signed [PART_W-1:0] parts [KSIZE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_last_reg <= s2_last_reg;
        for (int k = 0; k < KTAPS; k++)
        begin
            s3_term_reg[k] <= terms[k];
        end
    end

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            parts[i] = PART_W'(s3_term_reg[i*KSIZE])
                     + PART_W'(s3_term_reg[i*KSIZE + 1])
                     + PART_W'(s3_term_reg[i*KSIZE + 2]);
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: final sum and clamp
    // ---------------------------------------------------------------
    logic                     s4_valid_reg;
    logic                     s4_last_reg;
    logic signed [PART_W-1:0] s4_part_reg [KSIZE];
    logic signed [SUM_W-1:0]  total;
    pix_out_t                 result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_last_reg <= s3_last_reg;
        for (int i = 0; i < KSIZE; i++)
        begin
            s4_part_reg[i] <= parts[i];
        end
    end

    always_comb
    begin
        total = SUM_W'(s4_part_reg[0]) + SUM_W'(s4_part_reg[1]) + SUM_W'(s4_part_reg[2]);
        if (total < 0)
            result.pixel_out = 8'd0;
        else if (total > SUM_W'(255))
            result.pixel_out = 8'd255;
        else
            result.pixel_out = total[7:0];
        result.last_of_frame = s4_last_reg;
    end

    // ---------------------------------------------------------------
    // Result queue; input stalls when queue plus in-flight items could overflow
    // ---------------------------------------------------------------
    pix_out_t              fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_count_reg, fifo_count_next;
    logic                  fifo_wr, fifo_rd;
    logic [2:0]            inflight;
    logic [FIFO_CNT_W:0]   occupancy;

    assign fifo_wr   = s4_valid_reg;
    assign fifo_rd   = out_valid && out_ready;
    assign inflight  = 3'(s1_valid_reg) + 3'(s2_valid_reg) + 3'(s3_valid_reg)
                     + 3'(s4_valid_reg);
    assign occupancy = (FIFO_CNT_W + 1)'(fifo_count_reg) + (FIFO_CNT_W + 1)'(inflight);
    assign in_ready  = (32'(occupancy) < 32'(FIFO_DEPTH));

    always_comb
    begin
        fifo_count_next = fifo_count_reg;
        if (fifo_wr && !fifo_rd)
            fifo_count_next = fifo_count_reg + FIFO_CNT_W'(1);
        else if (!fifo_wr && fifo_rd)
            fifo_count_next = fifo_count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (fifo_wr)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (fifo_rd)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            fifo_count_reg <= fifo_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_wr)
        begin
            fifo_mem_reg[wr_ptr_reg] <= result;
        end
    end

    assign out_valid = (fifo_count_reg != '0);
    assign out_data  = fifo_mem_reg[rd_ptr_reg];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Queue never written while full unless a read happens in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_wr && !fifo_rd && (32'(fifo_count_reg) == 32'(FIFO_DEPTH))))
        else $error("result queue overflow");

    // Queue plus pipeline never exceed queue capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(occupancy) <= 32'(FIFO_DEPTH))
        else $error("in-flight items exceed queue room");

    // Bypass only when the previous cycle held an item writing the stores
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> $past(s1_valid_reg))
        else $error("line store bypass without a preceding write");

    // Frame end returns the position to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> (col_reg == '0) && (row_reg == '0))
        else $error("position not reset after last of frame");

    // An accepted item is in stage 1 in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted item missing from stage 1");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for conv3x3_image_filter_core, the streaming 3x3 image filter.
// Depends on conv3x3_pkg; predicts every filtered pixel and checks the output stream in order.
module testbench;
    import conv3x3_pkg::*;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    pix_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    pix_out_t              out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_COEF_TOP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: kernel, sizes, line buffers, neighborhood and position
    logic [CFG_DATA_W-1:0]   kernel_row [KSIZE] = '{RST_COEF_EDGE, RST_COEF_MID, RST_COEF_EDGE};
    logic [WIDTH_REG_W-1:0]  width_reg = RST_IMAGE_WIDTH;
    logic [HEIGHT_REG_W-1:0] height_reg = RST_IMAGE_HEIGHT;
    bit [7:0]                older_row [MAX_W];
    bit [7:0]                newer_row [MAX_W];
    bit [7:0]                nbhd [KTAPS];
    int                      next_col = 0;
    int                      next_row = 0;

    pix_out_t pending_pixels [$];
    int       mismatch_count = 0;
    int       pixels_accepted = 0;
    bit       steady_flow = 1'b0;

    conv3x3_image_filter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Clamp a size register to the range 1..limit
    function automatic int effective_size(input int raw, input int limit);
        if (raw < 1)
            return 1;
        if (raw > limit)
            return limit;
        return raw;
    endfunction

    // Advance the filter by one accepted transfer and queue the pixel it completes
    function automatic void predict_filtered(input pix_in_t word);
        int w, h, c, r, ro, co, acc, yr, xc, pv, cv, i, j;
        bit [7:0] fresh, above, beside;
        bit at_end;
        pix_out_t res;
        w = effective_size(width_reg, MAX_W);
        h = effective_size(height_reg, MAX_H);
        fresh = word.flush ? 8'd0 : word.pixel_in;
        c = next_col;
        r = next_row;
        above = 8'd0;
        beside = 8'd0;
        if (c < MAX_W)
        begin
            above = older_row[c];
            beside = newer_row[c];
            older_row[c] = beside;
            newer_row[c] = fresh;
        end
        // shift the neighborhood one column left, new column enters on the right
        for (i = 0; i < KSIZE; i++)
        begin
            nbhd[i*KSIZE]     = nbhd[i*KSIZE + 1];
            nbhd[i*KSIZE + 1] = nbhd[i*KSIZE + 2];
        end
        nbhd[2] = above;
        nbhd[5] = beside;
        nbhd[8] = fresh;

        // a column-zero transfer completes the last pixel of the row before last
        if (c >= 1)
        begin
            ro = r - 1;
            co = c - 1;
        end
        else
        begin
            ro = r - 2;
            co = w - 1;
        end

        at_end = 1'b0;
        if (ro >= 0 && ro < h && co < w)
        begin
            acc = 0;
            for (i = 0; i < KSIZE; i++)
            begin
                yr = ro - 1 + i;
                if (yr >= 0 && yr < h)
                begin
                    for (j = 0; j < KSIZE; j++)
                    begin
                        xc = co - 1 + j;
                        if (xc >= 0 && xc < w)
                        begin
                            pv = nbhd[i*KSIZE + j];
                            cv = $signed(kernel_row[i][COEF_W*j +: COEF_W]);
                            // integer division truncates toward zero
                            acc += (pv * cv) / 256;
                        end
                    end
                end
            end
            if (acc < 0)
                acc = 0;
            if (acc > 255)
                acc = 255;
            at_end = (ro == h - 1) && (co == w - 1);
            res.pixel_out = acc[7:0];
            res.last_of_frame = at_end;
            pending_pixels.push_back(res);
        end

        c += 1;
        if (c >= w)
        begin
            c = 0;
            r += 1;
        end
        if (at_end || r > h + 1)
        begin
            c = 0;
            r = 0;
        end
        next_col = c;
        next_row = r;
    endfunction

    // Three coefficients: full random, small fractions, or within +-1.0
    function automatic logic [CFG_DATA_W-1:0] random_kernel_row();
        logic [CFG_DATA_W-1:0] row;
        int k, cv, style;
        style = $urandom_range(0, 2);
        for (k = 0; k < KSIZE; k++)
        begin
            case (style)
                0:       cv = $urandom_range(0, 65535);
                1:       cv = int'($urandom_range(0, 160)) - 80;
                default: cv = int'($urandom_range(0, 512)) - 256;
            endcase
            row[COEF_W*k +: COEF_W] = cv[COEF_W-1:0];
        end
        return row;
    endfunction

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_COEF_TOP:     kernel_row[0] = value;
            REG_COEF_MID:     kernel_row[1] = value;
            REG_COEF_BOTTOM:  kernel_row[2] = value;
            REG_IMAGE_WIDTH:  width_reg = value[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = value[HEIGHT_REG_W-1:0];
            default: ;
        endcase
    endtask

    // Present one input word, hold it until the transfer, then predict
    task automatic send_item(input bit [7:0] value, input bit is_flush);
        pix_in_t word;
        word.pixel_in = value;
        word.flush = is_flush;
        while (!steady_flow && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_filtered(word);
        pixels_accepted++;
    endtask

    // Hold off input until every queued pixel is out and the pipeline has emptied
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Feed random words until the position wraps back to the frame start
    task automatic return_to_frame_start(input int flush_pct);
        while (next_col != 0 || next_row != 0)
            send_item($urandom_range(0, 255), $urandom_range(0, 99) < flush_pct);
    endtask

    // One well-formed frame at the current sizes followed by its drain
    task automatic run_frame(input int flush_pct, input int stray_pct);
        int w, h, n;
        w = effective_size(width_reg, MAX_W);
        h = effective_size(height_reg, MAX_H);
        for (n = 0; n < w * h; n++)
            send_item($urandom_range(0, 255), $urandom_range(0, 99) < flush_pct);
        // drain items; some are real pixels that fall outside the image
        for (n = 0; n <= w; n++)
            send_item($urandom_range(0, 255), $urandom_range(0, 99) >= stray_pct);
        return_to_frame_start(0);
    endtask

    // Reset kernel and full row width; this frame also fills both line buffers
    task automatic test_reset_defaults();
        wait_until_idle();
        write_reg(REG_IMAGE_HEIGHT, 2);
        run_frame(3, 20);
    endtask

    // Extreme coefficients and pixels, flush inside the frame, pixels in the drain
    task automatic test_corner_values();
        pix_in_t corner_frame [17] = '{
            {8'd0,   1'b0}, {8'd255, 1'b0}, {8'd255, 1'b0}, {8'd0,   1'b0},
            {8'd128, 1'b0}, {8'd255, 1'b1}, {8'd255, 1'b0}, {8'd1,   1'b0},
            {8'd255, 1'b0}, {8'd255, 1'b0}, {8'd0,   1'b0}, {8'd254, 1'b0},
            {8'd0,   1'b1}, {8'd255, 1'b0}, {8'hAA,  1'b1}, {8'd77,  1'b0},
            {8'd0,   1'b1}
        };
        int n;
        wait_until_idle();
        write_reg(REG_COEF_TOP,    48'h8000_7FFF_0001);
        write_reg(REG_COEF_MID,    48'h0080_FF00_0100);
        write_reg(REG_COEF_BOTTOM, 48'h7FFF_0000_FFFF);
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 3);
        foreach (corner_frame[n])
            send_item(corner_frame[n].pixel_in, corner_frame[n].flush);

        // zero sizes act as a single-pixel frame; largest centre weight saturates
        wait_until_idle();
        write_reg(REG_COEF_MID, 48'h0000_7FFF_0000);
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        send_item(8'd200, 1'b0);
        send_item(8'd9, 1'b0);
        send_item(8'd0, 1'b1);
    endtask

    // Oversized registers clamp to the widest row and the tallest column
    task automatic test_size_limits();
        wait_until_idle();
        write_reg(REG_COEF_TOP, random_kernel_row());
        write_reg(REG_COEF_MID, random_kernel_row());
        write_reg(REG_COEF_BOTTOM, random_kernel_row());
        write_reg(REG_IMAGE_WIDTH, 4095);
        write_reg(REG_IMAGE_HEIGHT, 0);
        run_frame(5, 30);
        wait_until_idle();
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 8191);
        run_frame(5, 30);
    endtask

    // Change width or height partway through a frame, then run on to the restart
    task automatic test_resize_mid_frame();
        int start_w [3] = '{6, 5, 3};
        int start_h [3] = '{5, 4, 3};
        int partial [3] = '{14, 12, 4};
        logic [CFG_IDX_W-1:0] changed [3] = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH};
        int new_size [3] = '{3, 1, 9};
        int k, n;
        for (k = 0; k < 3; k++)
        begin
            wait_until_idle();
            write_reg(REG_COEF_TOP, random_kernel_row());
            write_reg(REG_IMAGE_WIDTH, start_w[k]);
            write_reg(REG_IMAGE_HEIGHT, start_h[k]);
            for (n = 0; n < partial[k]; n++)
                send_item($urandom_range(0, 255), 1'b0);
            wait_until_idle();
            write_reg(changed[k], new_size[k]);
            return_to_frame_start(20);
        end
    endtask

    // Random frames, mostly small; some broken by a mid-frame size change
    task automatic test_random_frames();
        int start, w, h, cut, n, pick;
        bit first;
        start = pixels_accepted;
        first = 1'b1;
        while (pixels_accepted - start < 1300)
        begin
            steady_flow = (pixels_accepted - start) < 250;
            if (first || $urandom_range(0, 99) < 40)
            begin
                wait_until_idle();
                if ($urandom_range(0, 1))
                    write_reg(REG_COEF_TOP, random_kernel_row());
                if ($urandom_range(0, 1))
                    write_reg(REG_COEF_MID, random_kernel_row());
                if ($urandom_range(0, 1))
                    write_reg(REG_COEF_BOTTOM, random_kernel_row());
                pick = $urandom_range(0, 99);
                write_reg(REG_IMAGE_WIDTH, pick < 5 ? 0 :
                          pick < 10 ? $urandom_range(17, 160) : $urandom_range(1, 16));
                pick = $urandom_range(0, 99);
                write_reg(REG_IMAGE_HEIGHT, pick < 5 ? 0 :
                          pick < 10 ? $urandom_range(9, 24) : $urandom_range(1, 8));
                first = 1'b0;
            end
            if ($urandom_range(0, 99) < 12)
            begin
                w = effective_size(width_reg, MAX_W);
                h = effective_size(height_reg, MAX_H);
                cut = $urandom_range(0, w * h);
                for (n = 0; n < cut; n++)
                    send_item($urandom_range(0, 255), $urandom_range(0, 99) < 10);
                wait_until_idle();
                write_reg(REG_IMAGE_WIDTH, $urandom_range(1, 12));
                write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 8));
                return_to_frame_start(30);
            end
            else
                run_frame(6, 25);
        end
        steady_flow = 1'b0;
    endtask

    // Compare each output transfer with the oldest predicted pixel
    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                if (mismatch_count < 40)
                    $display("%0t: expected nothing, got pixel_out %0d last_of_frame %0b",
                             $time, out_data.pixel_out, out_data.last_of_frame);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_data.pixel_out !== want.pixel_out)
                begin
                    if (mismatch_count < 40)
                        $display("%0t: pixel_out expected %0d, got %0d",
                                 $time, want.pixel_out, out_data.pixel_out);
                    mismatch_count++;
                end
                if (out_data.last_of_frame !== want.last_of_frame)
                begin
                    if (mismatch_count < 40)
                        $display("%0t: last_of_frame expected %0b, got %0b",
                                 $time, want.last_of_frame, out_data.last_of_frame);
                    mismatch_count++;
                end
            end
        end
        out_ready <= steady_flow || ($urandom_range(0, 99) >= 28);
    end

    // Run the tests in turn, then settle and report
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_corner_values();
        test_size_limits();
        test_resize_mid_frame();
        test_random_frames();
        wait_until_idle();
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: conv3x3_image_filter_core.f
design/conv3x3_pkg.sv
design/conv3x3_ram.sv
design/conv3x3_image_filter_core.sv
verif/testbench.sv
